/* hw/rtl/rgbbf_pkg.sv */
// shared types, register codes and the factor selector of the blend unit
// no dependencies
`default_nettype none

package rgbbf_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SOURCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SHIFT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MASK   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_ALPHA   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_RGB     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FACTOR   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_FACTOR   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_OP     = 8'd7;

    // alpha source codes
    localparam logic [1:0] ASRC_FIELD = 2'd0;
    localparam logic [1:0] ASRC_GRAY  = 2'd1;
    localparam logic [1:0] ASRC_CONST = 2'd2;

    // factor codes
    localparam logic [3:0] FACTOR_ZERO          = 4'd0;
    localparam logic [3:0] FACTOR_ONE           = 4'd1;
    localparam logic [3:0] FACTOR_SRC_ALPHA     = 4'd2;
    localparam logic [3:0] FACTOR_INV_SRC_ALPHA = 4'd3;
    localparam logic [3:0] FACTOR_DST_ALPHA     = 4'd4;
    localparam logic [3:0] FACTOR_INV_DST_ALPHA = 4'd5;
    localparam logic [3:0] FACTOR_SRC_COLOR     = 4'd6;
    localparam logic [3:0] FACTOR_DST_COLOR     = 4'd7;
    localparam logic [3:0] FACTOR_INV_SRC_COLOR = 4'd8;
    localparam logic [3:0] FACTOR_INV_DST_COLOR = 4'd9;

    // blend operation codes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_SUB     = 2'd1;
    localparam logic [1:0] OP_REV_SUB = 2'd2;
    localparam logic [1:0] OP_KEEP    = 2'd3;

    localparam logic [7:0] FULL = 8'd255;

    typedef struct packed {
        logic [3:0] src_factor;
        logic [3:0] dst_factor;
        logic [1:0] blend_op;
        logic       tint_on;
    } t_mix_cfg;

    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } t_stage_en;

    typedef struct packed {
        logic zero;
        logic opaque;
    } t_pix_sel;

    function automatic logic [7:0] pick_factor(input logic [3:0] code, input logic [7:0] a,
                                               input logic [7:0] s, input logic [7:0] d);
        logic [7:0] f;
        unique case (code)
            FACTOR_ZERO:          f = 8'd0;
            FACTOR_ONE:           f = FULL;
            FACTOR_SRC_ALPHA:     f = a;
            FACTOR_INV_SRC_ALPHA: f = FULL - a;
            FACTOR_DST_ALPHA:     f = FULL;
            FACTOR_INV_DST_ALPHA: f = 8'd0;
            FACTOR_SRC_COLOR:     f = s;
            FACTOR_DST_COLOR:     f = d;
            FACTOR_INV_SRC_COLOR: f = FULL - s;
            FACTOR_INV_DST_COLOR: f = FULL - d;
            default:              f = FULL;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgb24_blend_factor_unit.sv */
// top level of the rgb24 blend unit: configuration registers, alpha path, pipeline control
// depends on rgbbf_pkg and rgbbf_lane
//
// Takes one pixel per clock unless the output stalls, and returns one result per pixel.
// Stage one extracts alpha from the source word, stage two applies the tint
// multipliers, stage three forms the source and destination factor products (one 8x8
// multiply per product and channel), stage four combines them into the output register.
// Each stage holds its own valid bit and stalls only when the stage after it is full, so a
// stalled output does not stop the pipeline from filling. Configuration writes are always
// taken and should only be made while no pixel is in flight.
`default_nettype none

module rgb24_blend_factor_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel input
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // source_word, src_red, src_green, src_blue, dst_red, dst_green, dst_blue
    input  wire logic [79:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tlast,
    // pixel output
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]      o_m_axis_tdata,
    // was_written
    output logic             o_m_axis_tuser,
    output logic             o_m_axis_tlast,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rgbbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rgbbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]  r_alpha_source;
    logic [4:0]  r_alpha_shift;
    logic [7:0]  r_alpha_mask;
    logic [7:0]  r_tint_alpha;
    logic [23:0] r_tint_rgb;
    logic [3:0]  r_src_factor;
    logic [3:0]  r_dst_factor;
    logic [1:0]  r_blend_op;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1;
    rgbbf_pkg::t_stage_en w_en;
    rgbbf_pkg::t_mix_cfg  w_cfg;
    rgbbf_pkg::t_pix_sel  w_sel;

    logic [31:0] w_word;
    logic [31:0] w_shifted;
    logic [7:0]  n_a1;
    logic [15:0] w_alpha_prod;

    logic [7:0]  r_a1;
    logic [7:0]  r_src1 [3];
    logic [7:0]  r_dst1 [3];
    logic        r_last1;
    logic [7:0]  r_a2;
    logic        r_zero2;
    logic        r_last2;
    logic        r_zero3;
    logic        r_opaque3;
    logic        r_last3;
    logic        r_wr4;
    logic        r_last4;
    logic [7:0]  w_chan [3];

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_source <= rgbbf_pkg::ASRC_FIELD;
            r_alpha_shift  <= 5'd24;
            r_alpha_mask   <= 8'd255;
            r_tint_alpha   <= 8'd0;
            r_tint_rgb     <= 24'hFFFFFF;
            r_src_factor   <= rgbbf_pkg::FACTOR_SRC_ALPHA;
            r_dst_factor   <= rgbbf_pkg::FACTOR_INV_SRC_ALPHA;
            r_blend_op     <= rgbbf_pkg::OP_ADD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rgbbf_pkg::REG_ALPHA_SOURCE: r_alpha_source <= i_cfg_data[1:0];
                rgbbf_pkg::REG_ALPHA_SHIFT:  r_alpha_shift  <= i_cfg_data[4:0];
                rgbbf_pkg::REG_ALPHA_MASK:   r_alpha_mask   <= i_cfg_data[7:0];
                rgbbf_pkg::REG_TINT_ALPHA:   r_tint_alpha   <= i_cfg_data[7:0];
                rgbbf_pkg::REG_TINT_RGB:     r_tint_rgb     <= i_cfg_data[23:0];
                rgbbf_pkg::REG_SRC_FACTOR:   r_src_factor   <= i_cfg_data[3:0];
                rgbbf_pkg::REG_DST_FACTOR:   r_dst_factor   <= i_cfg_data[3:0];
                rgbbf_pkg::REG_BLEND_OP:     r_blend_op     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.src_factor = r_src_factor;
    assign w_cfg.dst_factor = r_dst_factor;
    assign w_cfg.blend_op   = r_blend_op;
    assign w_cfg.tint_on    = (r_tint_alpha != 8'd0);

    // stage handshake
    assign w_en.en4 = !r_v4 || i_m_axis_tready;
    assign w_en.en3 = !r_v3 || w_en.en4;
    assign w_en.en2 = !r_v2 || w_en.en3;
    assign w_en1    = !r_v1 || w_en.en2;
    assign o_s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1)    r_v1 <= i_s_axis_tvalid;
            if (w_en.en2) r_v2 <= r_v1;
            if (w_en.en3) r_v3 <= r_v2;
            if (w_en.en4) r_v4 <= r_v3;
        end
    end

    // stage 1: alpha extraction
    assign w_word    = i_s_axis_tdata[31:0];
    assign w_shifted = w_word >> r_alpha_shift;

    always_comb begin
        unique case (r_alpha_source)
            rgbbf_pkg::ASRC_GRAY:  n_a1 = (w_word[7:0] != 8'd0) ? rgbbf_pkg::FULL : 8'd0;
            rgbbf_pkg::ASRC_CONST: n_a1 = rgbbf_pkg::FULL;
            default:               n_a1 = w_shifted[7:0] & r_alpha_mask;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_a1      <= n_a1;
            r_src1[0] <= i_s_axis_tdata[39:32];
            r_src1[1] <= i_s_axis_tdata[47:40];
            r_src1[2] <= i_s_axis_tdata[55:48];
            r_dst1[0] <= i_s_axis_tdata[63:56];
            r_dst1[1] <= i_s_axis_tdata[71:64];
            r_dst1[2] <= i_s_axis_tdata[79:72];
            r_last1   <= i_s_axis_tlast;
        end
    end

    // stage 2: alpha tint
    assign w_alpha_prod = r_a1 * r_tint_alpha;

    always_ff @(posedge i_clk) begin
        if (w_en.en2) begin
            r_a2    <= w_cfg.tint_on ? w_alpha_prod[15:8] : r_a1;
            r_zero2 <= (r_a1 == 8'd0);
            r_last2 <= r_last1;
        end
    end

    // stage 3: pixel flags
    always_ff @(posedge i_clk) begin
        if (w_en.en3) begin
            r_zero3   <= r_zero2;
            r_opaque3 <= (r_a2 == rgbbf_pkg::FULL);
            r_last3   <= r_last2;
        end
    end

    assign w_sel.zero   = r_zero3;
    assign w_sel.opaque = r_opaque3;

    // stage 4: result flags
    always_ff @(posedge i_clk) begin
        if (w_en.en4) begin
            r_wr4   <= !r_zero3;
            r_last4 <= r_last3;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rgbbf_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_cfg   (w_cfg),
            .i_tint  (r_tint_rgb[23-8*g -: 8]),
            .i_src   (r_src1[g]),
            .i_dst   (r_dst1[g]),
            .i_alpha (r_a2),
            .i_sel   (w_sel),
            .o_chan  (w_chan[g])
        );
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {w_chan[2], w_chan[1], w_chan[0]};
    assign o_m_axis_tuser  = r_wr4;
    assign o_m_axis_tlast  = r_last4;

endmodule

`default_nettype wire

/* hw/rtl/rgbbf_lane.sv */
// one color channel of the blend pipeline: tint, factor products, combine
// depends on rgbbf_pkg; stage enables and pixel flags come from the top level
`default_nettype none

module rgbbf_lane (
    input  wire logic                i_clk,
    input  wire rgbbf_pkg::t_stage_en i_en,
    input  wire rgbbf_pkg::t_mix_cfg  i_cfg,
    input  wire logic [7:0]          i_tint,
    input  wire logic [7:0]          i_src,
    input  wire logic [7:0]          i_dst,
    input  wire logic [7:0]          i_alpha,
    input  wire rgbbf_pkg::t_pix_sel  i_sel,
    output logic [7:0]               o_chan
);

    logic [15:0] w_tint_prod;
    logic [7:0]  w_fs;
    logic [7:0]  w_fd;
    logic [16:0] w_sum;
    logic [15:0] w_diff_sd;
    logic [15:0] w_diff_ds;
    logic [7:0]  w_mix;
    logic [7:0]  n_chan;

    logic [7:0]  r_s2;
    logic [7:0]  r_d2;
    logic [15:0] r_ps;
    logic [15:0] r_pd;
    logic [7:0]  r_s3;
    logic [7:0]  r_d3;
    logic [7:0]  r_chan;

    assign w_tint_prod = i_src * i_tint;

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_s2 <= i_cfg.tint_on ? w_tint_prod[15:8] : i_src;
            r_d2 <= i_dst;
        end
    end

    assign w_fs = rgbbf_pkg::pick_factor(i_cfg.src_factor, i_alpha, r_s2, r_d2);
    assign w_fd = rgbbf_pkg::pick_factor(i_cfg.dst_factor, i_alpha, r_s2, r_d2);

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_ps <= r_s2 * w_fs;
            r_pd <= r_d2 * w_fd;
            r_s3 <= r_s2;
            r_d3 <= r_d2;
        end
    end

    assign w_sum     = {1'b0, r_ps} + {1'b0, r_pd};
    assign w_diff_sd = r_ps - r_pd;
    assign w_diff_ds = r_pd - r_ps;

    always_comb begin
        unique case (i_cfg.blend_op)
            rgbbf_pkg::OP_ADD:     w_mix = w_sum[15:8];
            rgbbf_pkg::OP_SUB:     w_mix = (r_ps < r_pd) ? 8'd0 : w_diff_sd[15:8];
            rgbbf_pkg::OP_REV_SUB: w_mix = (r_pd < r_ps) ? 8'd0 : w_diff_ds[15:8];
            rgbbf_pkg::OP_KEEP:    w_mix = r_d3;
        endcase
    end

    always_comb begin
        priority if (i_sel.zero) begin
            n_chan = r_d3;
        end else if (i_sel.opaque) begin
            n_chan = r_s3;
        end else begin
            n_chan = w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

`default_nettype wire
